// ===== rtl/core/ldet_pkg.sv =====
// Shared types and field widths for the LRU data eviction tracker.
`default_nettype none

package ldet_pkg;

  localparam int ENTRY_W = 16;  // entry_index / evict_index field width
  localparam int CFG_W   = 5;   // cache_size register width

  localparam logic KIND_TOUCH = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [ENTRY_W-1:0] entry_index;
    logic               has_data;
  } ldet_in_t;

  typedef struct packed {
    logic               was_listed;
    logic               evict_valid;
    logic [ENTRY_W-1:0] evict_index;
  } ldet_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/lru_data_eviction_tracker.sv =====
// LRU replacement list: move-to-front recency list with back-of-list eviction.
//
//   channel | ports                          | beat taken when
//   --------+--------------------------------+---------------------------
//   input   | start, busy, in_item           | start && !busy
//   result  | out_valid, out_item            | out_valid (one cycle)
//   config  | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
//
// A clear does not leave idle; its result shows the next cycle and busy stays low.
// A touch with a list of n entries searches up to n slots, one by one, for the index,
// then decides; if it lists the entry, it moves each slot down one place, writes the
// front slot and, if the back entry is evicted, reports that in a step of its own.
// All of it runs through one comparator and the list memory (one read port,
// one write port).
// rst_n is synchronous; it empties the list and sets cache_size to zero.
// The result is shown for exactly one cycle and cannot be stalled.
`default_nettype none

module lru_data_eviction_tracker #(
  parameter int MAX_CACHE  = 16,
  parameter int INDEX_BITS = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  ldet_pkg::ldet_in_t      in_item,
  output logic                    out_valid,
  output ldet_pkg::ldet_out_t     out_item,
  input  wire                     cfg_valid,
  output logic                    cfg_ready,
  input  wire [ldet_pkg::CFG_W-1:0] cfg_data
);
  import ldet_pkg::*;

  localparam int DEPTH = MAX_CACHE + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_PUSH   = 6'b010000,
    S_EVICT  = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [AW-1:0]           ptr_r, ptr_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic                    found_r, found_nxt;
  logic [INDEX_BITS-1:0]   idx_r, idx_nxt;
  logic                    has_data_r, has_data_nxt;
  logic [CFG_W-1:0]        cache_size_r;
  logic                    out_valid_r, out_valid_nxt;
  ldet_out_t               out_item_r, out_item_nxt;

  logic [INDEX_BITS-1:0]   list_mem [DEPTH];
  logic [INDEX_BITS-1:0]   rd_data_r;
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;
  logic [AW-1:0]           mem_wa;
  logic [INDEX_BITS-1:0]   mem_wd;

  logic [CW-1:0]           limit;
  logic                    in_beat;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign in_beat   = start && !busy;

  // cache sizes above MAX_CACHE saturate
  always_comb begin
    if (32'(cache_size_r) > MAX_CACHE) begin
      limit = CW'(MAX_CACHE);
    end else begin
      limit = CW'(cache_size_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      list_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= list_mem[rd_addr];
  end

  always_comb begin
    logic [AW-1:0] shift_end;
    shift_end     = '0;
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    count_nxt     = count_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    has_data_nxt  = has_data_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = idx_r;
    rd_addr       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          if (in_item.kind == KIND_CLEAR) begin
            count_nxt     = '0;
            out_valid_nxt = 1'b1;
            out_item_nxt  = '0;
          end else begin
            idx_nxt      = INDEX_BITS'(in_item.entry_index);
            has_data_nxt = in_item.has_data;
            found_nxt    = 1'b0;
            ptr_nxt      = '0;
            state_nxt    = (count_r == '0) ? S_DECIDE : S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        rd_addr = ptr_r + AW'(1);
        if (rd_data_r == idx_r) begin
          found_nxt = 1'b1;        // ptr_r keeps the hit slot
          state_nxt = S_DECIDE;
        end else if (CW'(ptr_r) + CW'(1) == count_r) begin
          state_nxt = S_DECIDE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_DECIDE: begin
        if (limit != '0 && has_data_r) begin
          if (found_r) begin
            shift_end = ptr_r;
          end else begin
            shift_end = AW'(count_r);
            count_nxt = count_r + CW'(1);
          end
          if (shift_end == '0) begin
            state_nxt = S_PUSH;
          end else begin
            ptr_nxt   = shift_end;
            rd_addr   = shift_end - AW'(1);
            state_nxt = S_SHIFT;
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{was_listed: found_r, evict_valid: 1'b0, evict_index: '0};
          state_nxt     = S_IDLE;
        end
      end
      S_SHIFT: begin
        // slot ptr takes slot ptr-1, read in the previous cycle
        mem_we  = 1'b1;
        mem_wa  = ptr_r;
        mem_wd  = rd_data_r;
        rd_addr = ptr_r - AW'(2);
        if (ptr_r == AW'(1)) begin
          state_nxt = S_PUSH;
        end else begin
          ptr_nxt = ptr_r - AW'(1);
        end
      end
      S_PUSH: begin
        mem_we  = 1'b1;
        mem_wa  = '0;
        mem_wd  = idx_r;
        rd_addr = AW'(count_r - CW'(1));
        if (count_r > limit) begin
          state_nxt = S_EVICT;
        end else begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{was_listed: found_r, evict_valid: 1'b0, evict_index: '0};
          state_nxt     = S_IDLE;
        end
      end
      S_EVICT: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{was_listed: found_r, evict_valid: 1'b1,
                          evict_index: ENTRY_W'(rd_data_r)};
        count_nxt     = count_r - CW'(1);
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      cache_size_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cache_size_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    found_r    <= found_nxt;
    idx_r      <= idx_nxt;
    has_data_r <= has_data_nxt;
    out_item_r <= out_item_nxt;
  end

`ifndef NO_ASSERTIONS
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> count_r <= CW'(MAX_CACHE))
    else $error("list longer than MAX_CACHE between items");

  a_evict_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.evict_valid |-> $past(state_r) == S_EVICT)
    else $error("eviction reported outside the evict step");

  a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.evict_valid |-> out_item_r.evict_index == '0)
    else $error("evict_index nonzero without eviction");

  a_shift_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> ptr_r != '0 && CW'(ptr_r) < count_r)
    else $error("shift pointer outside the list");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for lru_data_eviction_tracker: random touches and clears with a scoreboard.
`default_nettype none

module tb_top;
  import ldet_pkg::*;

  localparam int LIST_SLOTS = 17;  // capacity plus the slot used while pushing
  localparam int CAP_MAX    = 16;

  class lru_scoreboard;
    logic [ENTRY_W-1:0] slots [0:LIST_SLOTS-1];
    int unsigned        fill;
    int unsigned        cache_limit;
    ldet_out_t          due_q [$];
    int                 errors;

    function new();
      fill        = 0;
      cache_limit = 0;
      errors      = 0;
    endfunction

    function void set_size(input logic [CFG_W-1:0] v);
      cache_limit = (v > CAP_MAX) ? CAP_MAX : v;
    endfunction

    // work out the result of one accepted beat and queue it
    function void note_input(input ldet_in_t it);
      ldet_out_t r;
      int        found;
      int        shift_end;
      int        i;
      r     = '0;
      found = -1;
      if (it.kind == KIND_CLEAR) begin
        fill = 0;
        due_q.push_back(r);
        return;
      end
      for (i = 0; i < fill; i++)
        if (found < 0 && slots[i] == it.entry_index) found = i;
      if (cache_limit > 0 && it.has_data) begin
        if (found >= 0) begin
          shift_end = found;
        end else begin
          if (fill < LIST_SLOTS) fill++;
          shift_end = fill - 1;
        end
        for (i = shift_end; i > 0; i--) slots[i] = slots[i-1];
        slots[0] = it.entry_index;
        // a lowered size only drops one entry per touch
        if (fill > cache_limit) begin
          r.evict_valid = 1'b1;
          r.evict_index = slots[fill-1];
          fill--;
        end
      end
      r.was_listed = (found >= 0);
      due_q.push_back(r);
    endfunction

    function void check_result(input ldet_out_t got);
      ldet_out_t want;
      if (due_q.size() == 0) begin
        $error("result with nothing expected: %0h", got);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got.was_listed !== want.was_listed) begin
        $error("was_listed: expected %0h, got %0h", want.was_listed, got.was_listed);
        errors++;
      end
      if (got.evict_valid !== want.evict_valid) begin
        $error("evict_valid: expected %0h, got %0h", want.evict_valid, got.evict_valid);
        errors++;
      end
      if (got.evict_index !== want.evict_index) begin
        $error("evict_index: expected %0h, got %0h", want.evict_index, got.evict_index);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  ldet_in_t         in_item;
  logic             out_valid;
  ldet_out_t        out_item;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  lru_scoreboard board;
  int            idle_pct;

  lru_data_eviction_tracker uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) board.check_result(out_item);
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic ldet_in_t touch(input logic [ENTRY_W-1:0] idx, input logic hd);
    ldet_in_t t;
    t.kind        = KIND_TOUCH;
    t.entry_index = idx;
    t.has_data    = hd;
    return t;
  endfunction

  function automatic ldet_in_t clear_beat();
    ldet_in_t t;
    t.kind        = KIND_CLEAR;
    t.entry_index = ENTRY_W'($urandom);
    t.has_data    = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_item(input ldet_in_t it);
    in_item = it;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    board.note_input(it);
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (board.due_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.set_size(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0]   sz;
    logic [ENTRY_W-1:0] pool_base;
    logic [ENTRY_W-1:0] idx;
    int                 lim;
    logic [CFG_W-1:0]   plan [0:6];

    board     = new();
    start     = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    idle_pct  = 0;
    plan      = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd17, 5'd2};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // size zero after reset: tracking off
    send_item(touch(16'hFFFF, 1'b1));
    send_item(clear_beat());

    write_size(5'd2);
    send_item(touch(16'h0000, 1'b1));
    send_item(touch(16'hFFFF, 1'b1));
    send_item(touch(16'h0000, 1'b1));  // hit, moves to front
    send_item(touch(16'h1234, 1'b1));  // evicts FFFF
    send_item(touch(16'h1234, 1'b0));  // hit without data, list untouched
    send_item(touch(16'h5555, 1'b0));

    // above the capacity: saturates at 16
    write_size(5'd31);
    for (int i = 0; i < 17; i++) send_item(touch(16'hA5A5 ^ i[15:0], 1'b1));

    for (int p = 0; p < 12; p++) begin
      idle_pct  = (p < 4) ? 26 : (p < 8) ? 61 : 0;
      sz        = (p < 7) ? plan[p] : CFG_W'($urandom_range(0, 31));
      write_size(sz);
      lim       = (sz > CAP_MAX) ? CAP_MAX : sz;
      pool_base = ENTRY_W'($urandom);
      for (int n = 0; n < 152; n++) begin
        if ($urandom_range(0, 99) < 3) begin
          send_item(clear_beat());
        end else begin
          if ($urandom_range(0, 99) < 80) idx = pool_base + ENTRY_W'($urandom_range(0, lim + 3));
          else idx = ENTRY_W'($urandom);
          send_item(touch(idx, $urandom_range(0, 99) < 85));
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
